// ----- rtl/doe_pkg.sv -----
// doe_pkg: shared constants for the degeneracy order engine
// command codes, field widths and default sizes; no dependencies
package doe_pkg;

  // default store sizes
  localparam int DEF_MAX_VERTICES = 1024;
  localparam int DEF_MAX_EDGES    = 4096;

  // field widths fixed by the stream format
  localparam int CMD_W  = 2;
  localparam int VTX_W  = 10;
  localparam int CFG_W  = 11;
  localparam int DATA_W = 24;

  // command codes carried in tuser
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_NEXT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

endpackage

// ----- rtl/doe_ram.sv -----
// doe_ram: single write port, single read port synchronous memory
// read data registered; no dependencies
module doe_ram #(
  parameter int DEPTH  = 2,
  parameter int WIDTH  = 1,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/degeneracy_order_engine_core.sv -----
// degeneracy_order_engine_core: smallest-last degeneracy ordering over loaded edges
// edge load reads, writes and links each endpoint in turn; a next command probes buckets
//   upward from the lowest, pops an entry, walks its neighbours (pushing each unvisited
//   one into a bucket while pool space remains) and emits; the first next command adds a
//   bucket fill over MAX_VERTICES vertices, pushing each vertex below the vertex count
// one transaction in work at a time; a finished result waits in the output register
// reset and clear run a clearing pass over max(MAX_VERTICES, MAX_EDGES+1) entries with tready low
// depends on doe_pkg and doe_ram
module degeneracy_order_engine_core
  import doe_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
  input  logic              clk,
  input  logic              rst,
  // configuration: vertex_count
  input  logic              cfg_wen,
  input  logic [CFG_W-1:0]  cfg_wdata,
  // input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,   // vertex_a [9:0], vertex_b [19:10], zero fill
  input  logic [CMD_W-1:0]  s_tuser,   // command [1:0]
  // result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // ordered_vertex [9:0], rank [19:10], edges_dropped [20]
  output logic [0:0]        m_tuser,   // status [0]
  output logic              m_tlast    // last_of_order
);

  localparam int VW       = $clog2(MAX_VERTICES);
  localparam int NCW      = $clog2(MAX_VERTICES + 1);
  localparam int XW       = (NCW > CFG_W) ? NCW : CFG_W;
  localparam int NB_DEPTH = 2 * MAX_EDGES;
  localparam int NAW      = $clog2(NB_DEPTH);
  localparam int NW       = $clog2(NB_DEPTH + 1);
  localparam int POOL     = MAX_VERTICES + MAX_EDGES;
  localparam int PAW      = $clog2(POOL);
  localparam int PW       = $clog2(POOL + 1);
  localparam int BUCKETS  = MAX_EDGES + 1;
  localparam int DW       = $clog2(BUCKETS);
  localparam int BIW      = $clog2(BUCKETS + 1);
  localparam int EW       = $clog2(MAX_EDGES + 1);
  localparam int CLR_LEN  = (MAX_VERTICES > BUCKETS) ? MAX_VERTICES : BUCKETS;
  localparam int CLW      = $clog2(CLR_LEN);

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE,
    ST_L_RD, ST_L_WR, ST_L_LINK,
    ST_F_RD, ST_F_DEG, ST_F_PUSH,
    ST_N_TOP, ST_N_POP, ST_N_VERT, ST_N_VIS,
    ST_V_PTR, ST_V_NXT, ST_V_NBR, ST_V_UPD, ST_V_PUSH,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {PH_LOADING, PH_ORDERING, PH_DONE} phase_t;

  state_t             state;
  phase_t             phase;
  logic [CFG_W-1:0]   vertex_count;
  logic [EW-1:0]      edge_count;
  logic [DW-1:0]      max_degree;
  logic [BIW-1:0]     bkt_level;
  logic [NCW-1:0]     order_count;
  logic [PW-1:0]      entry_alloc;
  logic               dropped_flag;
  logic               side;
  logic [NCW-1:0]     fill_idx;
  logic [CLW-1:0]     clr_idx;
  logic [VTX_W-1:0]   vtx_a;
  logic [VTX_W-1:0]   vtx_b;
  logic [VW-1:0]      cur_v;
  logic [VW-1:0]      nbr_w;
  logic [NW-1:0]      ptr;
  logic [NW-1:0]      ptr_next;
  logic [NW-1:0]      tail_hold;
  logic [DW-1:0]      deg_hold;
  logic [VTX_W-1:0]   res_vertex;
  logic [VTX_W-1:0]   res_rank;
  logic               res_last;
  logic               res_status;

  // memory ports
  logic            nbv_we, nbn_we, hd_we, tl_we, dg_we, wd_we, vs_we, bkv_we, bkn_we, tp_we;
  logic [NAW-1:0]  nbv_wa, nbn_wa, nb_ra;
  logic [VW-1:0]   nbv_wd, nbv_rd;
  logic [NW-1:0]   nbn_wd, nbn_rd;
  logic [VW-1:0]   hd_wa, tl_wa, dg_wa, wd_wa, vs_wa, vx_ra, vs_ra;
  logic [NW-1:0]   hd_wd, hd_rd, tl_wd, tl_rd;
  logic [DW-1:0]   dg_wd, dg_rd, wd_wd, wd_rd;
  logic            vs_wd, vs_rd;
  logic [PAW-1:0]  bkv_wa, bkn_wa, bk_ra;
  logic [VW-1:0]   bkv_wd, bkv_rd;
  logic [PW-1:0]   bkn_wd, bkn_rd;
  logic [DW-1:0]   tp_wa, tp_ra;
  logic [PW-1:0]   tp_wd, tp_rd;

  // derived values
  logic [XW-1:0]   count_x;
  logic [XW-1:0]   n_x;
  logic [NCW-1:0]  n_act;
  logic            load_drop;
  logic [NAW-1:0]  slot;
  logic [NW-1:0]   slot_ptr;
  logic [VW-1:0]   load_v;
  logic [VW-1:0]   load_other;
  logic [DW-1:0]   wd_dec;
  logic            in_acc;
  logic            out_free;
  logic [NCW-1:0]  oc_inc;

  assign count_x    = XW'(vertex_count);
  assign n_x        = (count_x > XW'(MAX_VERTICES)) ? XW'(MAX_VERTICES) : count_x;
  assign n_act      = NCW'(n_x);
  assign load_drop  = (phase != PH_LOADING) || (XW'(s_tdata[9:0]) >= n_x)
                   || (XW'(s_tdata[19:10]) >= n_x) || (s_tdata[9:0] == s_tdata[19:10])
                   || (int'(edge_count) >= MAX_EDGES);
  assign slot       = NAW'({edge_count, side});
  assign slot_ptr   = NW'(slot) + NW'(1);
  assign load_v     = side ? VW'(vtx_b) : VW'(vtx_a);
  assign load_other = side ? VW'(vtx_a) : VW'(vtx_b);
  assign wd_dec     = (wd_rd != '0) ? (wd_rd - DW'(1)) : wd_rd;
  assign in_acc     = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign oc_inc     = order_count + NCW'(1);
  assign s_tready   = (state == ST_IDLE);

  // memory port steering
  always_comb begin
    nbv_we = 1'b0; nbv_wa = slot; nbv_wd = load_other;
    nbn_we = 1'b0; nbn_wa = slot; nbn_wd = '0;
    nb_ra  = NAW'(ptr - NW'(1));
    hd_we  = 1'b0; hd_wa = load_v; hd_wd = slot_ptr;
    tl_we  = 1'b0; tl_wa = load_v; tl_wd = slot_ptr;
    dg_we  = 1'b0; dg_wa = load_v; dg_wd = dg_rd + DW'(1);
    wd_we  = 1'b0; wd_wa = VW'(fill_idx); wd_wd = dg_rd;
    vs_we  = 1'b0; vs_wa = VW'(fill_idx); vs_wd = (fill_idx >= n_act);
    vx_ra  = load_v;
    vs_ra  = nbv_rd;
    bkv_we = 1'b0; bkv_wa = PAW'(entry_alloc); bkv_wd = VW'(fill_idx);
    bkn_we = 1'b0; bkn_wa = PAW'(entry_alloc); bkn_wd = tp_rd;
    bk_ra  = PAW'(tp_rd - PW'(1));
    tp_we  = 1'b0; tp_wa = deg_hold; tp_wd = PW'(entry_alloc) + PW'(1);
    tp_ra  = DW'(bkt_level);
    unique case (state)
      ST_CLR: begin
        hd_wa = VW'(clr_idx); tl_wa = VW'(clr_idx); dg_wa = VW'(clr_idx);
        hd_wd = '0; tl_wd = '0; dg_wd = '0;
        hd_we = (int'(clr_idx) < MAX_VERTICES);
        tl_we = hd_we;
        dg_we = hd_we;
        tp_wa = DW'(clr_idx); tp_wd = '0;
        tp_we = (int'(clr_idx) < BUCKETS);
      end
      ST_L_WR: begin
        nbv_we = 1'b1;
        nbn_we = 1'b1;
        dg_we  = 1'b1;
      end
      ST_L_LINK: begin
        nbn_wa = NAW'(tail_hold - NW'(1));
        nbn_wd = slot_ptr;
        nbn_we = (tail_hold != '0);
        hd_we  = (tail_hold == '0);
        tl_we  = 1'b1;
      end
      ST_F_RD: begin
        vx_ra = VW'(fill_idx);
      end
      ST_F_DEG: begin
        wd_we = 1'b1;
        vs_we = 1'b1;
        tp_ra = dg_rd;
      end
      ST_F_PUSH: begin
        bkv_we = (int'(entry_alloc) < POOL);
        bkn_we = bkv_we;
        tp_we  = bkv_we;
      end
      ST_N_VERT: begin
        tp_wa = DW'(bkt_level);
        tp_wd = bkn_rd;
        tp_we = 1'b1;
        vs_ra = bkv_rd;
      end
      ST_N_VIS: begin
        vs_wa = cur_v; vs_wd = 1'b1;
        vs_we = !vs_rd;
        vx_ra = cur_v;
      end
      ST_V_NBR: begin
        vx_ra = nbv_rd;
        vs_ra = nbv_rd;
      end
      ST_V_UPD: begin
        wd_wa  = nbr_w; wd_wd = wd_dec;
        wd_we  = !vs_rd;
        bkv_wd = nbr_w;
        bkv_we = !vs_rd && (int'(entry_alloc) < POOL);
        tp_ra  = wd_dec;
      end
      ST_V_PUSH: begin
        bkn_we = 1'b1;
        tp_we  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // neighbour list stores
  doe_ram #(.DEPTH(NB_DEPTH), .WIDTH(VW)) u_nbv (
    .clk, .we(nbv_we), .waddr(nbv_wa), .wdata(nbv_wd), .raddr(nb_ra), .rdata(nbv_rd));
  doe_ram #(.DEPTH(NB_DEPTH), .WIDTH(NW)) u_nbn (
    .clk, .we(nbn_we), .waddr(nbn_wa), .wdata(nbn_wd), .raddr(nb_ra), .rdata(nbn_rd));
  doe_ram #(.DEPTH(MAX_VERTICES), .WIDTH(NW)) u_head (
    .clk, .we(hd_we), .waddr(hd_wa), .wdata(hd_wd), .raddr(vx_ra), .rdata(hd_rd));
  doe_ram #(.DEPTH(MAX_VERTICES), .WIDTH(NW)) u_tail (
    .clk, .we(tl_we), .waddr(tl_wa), .wdata(tl_wd), .raddr(vx_ra), .rdata(tl_rd));

  // per-vertex stores
  doe_ram #(.DEPTH(MAX_VERTICES), .WIDTH(DW)) u_deg (
    .clk, .we(dg_we), .waddr(dg_wa), .wdata(dg_wd), .raddr(vx_ra), .rdata(dg_rd));
  doe_ram #(.DEPTH(MAX_VERTICES), .WIDTH(DW)) u_wdeg (
    .clk, .we(wd_we), .waddr(wd_wa), .wdata(wd_wd), .raddr(vx_ra), .rdata(wd_rd));
  doe_ram #(.DEPTH(MAX_VERTICES), .WIDTH(1)) u_vis (
    .clk, .we(vs_we), .waddr(vs_wa), .wdata(vs_wd), .raddr(vs_ra), .rdata(vs_rd));

  // bucket stacks
  doe_ram #(.DEPTH(POOL), .WIDTH(VW)) u_bkv (
    .clk, .we(bkv_we), .waddr(bkv_wa), .wdata(bkv_wd), .raddr(bk_ra), .rdata(bkv_rd));
  doe_ram #(.DEPTH(POOL), .WIDTH(PW)) u_bkn (
    .clk, .we(bkn_we), .waddr(bkn_wa), .wdata(bkn_wd), .raddr(bk_ra), .rdata(bkn_rd));
  doe_ram #(.DEPTH(BUCKETS), .WIDTH(PW)) u_tops (
    .clk, .we(tp_we), .waddr(tp_wa), .wdata(tp_wd), .raddr(tp_ra), .rdata(tp_rd));

  // sequencer, counters and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLR;
      phase        <= PH_LOADING;
      vertex_count <= '0;
      edge_count   <= '0;
      max_degree   <= '0;
      bkt_level    <= '0;
      order_count  <= '0;
      entry_alloc  <= '0;
      dropped_flag <= 1'b0;
      side         <= 1'b0;
      fill_idx     <= '0;
      clr_idx      <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      // configuration write, held once ordering has begun
      if (cfg_wen && phase == PH_LOADING) begin
        vertex_count <= cfg_wdata;
      end
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLR: begin
          if (int'(clr_idx) == CLR_LEN - 1) begin
            state <= ST_IDLE;
          end else begin
            clr_idx <= clr_idx + CLW'(1);
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            vtx_a <= s_tdata[9:0];
            vtx_b <= s_tdata[19:10];
            case (s_tuser)
              CMD_LOAD: begin
                if (load_drop) begin
                  dropped_flag <= 1'b1;
                end else begin
                  side  <= 1'b0;
                  state <= ST_L_RD;
                end
              end
              CMD_NEXT: begin
                res_vertex <= '0;
                res_rank   <= '0;
                res_last   <= 1'b0;
                res_status <= 1'b1;
                if (phase == PH_LOADING) begin
                  fill_idx <= '0;
                  state    <= ST_F_RD;
                end else if (phase == PH_ORDERING) begin
                  state <= ST_N_TOP;
                end else begin
                  state <= ST_OUT;
                end
              end
              CMD_CLEAR: begin
                phase        <= PH_LOADING;
                edge_count   <= '0;
                max_degree   <= '0;
                bkt_level    <= '0;
                order_count  <= '0;
                entry_alloc  <= '0;
                dropped_flag <= 1'b0;
                clr_idx      <= '0;
                state        <= ST_CLR;
              end
              default: begin
              end
            endcase
          end
        end
        // edge load, one endpoint per pass
        ST_L_RD: state <= ST_L_WR;
        ST_L_WR: begin
          tail_hold <= tl_rd;
          if ((dg_rd + DW'(1)) > max_degree) begin
            max_degree <= dg_rd + DW'(1);
          end
          state <= ST_L_LINK;
        end
        ST_L_LINK: begin
          if (side) begin
            edge_count <= edge_count + EW'(1);
            state      <= ST_IDLE;
          end else begin
            side  <= 1'b1;
            state <= ST_L_RD;
          end
        end
        // bucket fill over all vertices
        ST_F_RD: state <= ST_F_DEG;
        ST_F_DEG: begin
          deg_hold <= dg_rd;
          if (fill_idx < n_act) begin
            state <= ST_F_PUSH;
          end else if (int'(fill_idx) == MAX_VERTICES - 1) begin
            bkt_level   <= '0;
            order_count <= '0;
            phase       <= (n_act == '0) ? PH_DONE : PH_ORDERING;
            state       <= (n_act == '0) ? ST_OUT : ST_N_TOP;
          end else begin
            fill_idx <= fill_idx + NCW'(1);
            state    <= ST_F_RD;
          end
        end
        ST_F_PUSH: begin
          if (int'(entry_alloc) < POOL) begin
            entry_alloc <= entry_alloc + PW'(1);
          end
          if (int'(fill_idx) == MAX_VERTICES - 1) begin
            bkt_level   <= '0;
            order_count <= '0;
            phase       <= PH_ORDERING;
            state       <= ST_N_TOP;
          end else begin
            fill_idx <= fill_idx + NCW'(1);
            state    <= ST_F_RD;
          end
        end
        // pop the lowest non-empty bucket
        ST_N_TOP: begin
          if (bkt_level <= BIW'(max_degree)) begin
            state <= ST_N_POP;
          end else begin
            phase <= PH_DONE;
            state <= ST_OUT;
          end
        end
        ST_N_POP: begin
          if (tp_rd == '0) begin
            bkt_level <= bkt_level + BIW'(1);
            state     <= ST_N_TOP;
          end else begin
            state <= ST_N_VERT;
          end
        end
        ST_N_VERT: begin
          cur_v <= bkv_rd;
          state <= ST_N_VIS;
        end
        ST_N_VIS: begin
          state <= vs_rd ? ST_N_TOP : ST_V_PTR;
        end
        // walk the neighbour list of the chosen vertex
        ST_V_PTR: begin
          ptr   <= hd_rd;
          state <= ST_V_NXT;
        end
        ST_V_NXT: begin
          if (ptr == '0) begin
            res_vertex  <= VTX_W'(cur_v);
            res_rank    <= VTX_W'(order_count);
            res_last    <= (oc_inc >= n_act);
            res_status  <= 1'b0;
            order_count <= oc_inc;
            if (oc_inc >= n_act) begin
              phase <= PH_DONE;
            end
            state <= ST_OUT;
          end else begin
            state <= ST_V_NBR;
          end
        end
        ST_V_NBR: begin
          nbr_w    <= nbv_rd;
          ptr_next <= nbn_rd;
          state    <= ST_V_UPD;
        end
        ST_V_UPD: begin
          deg_hold <= wd_dec;
          if (!vs_rd) begin
            if (BIW'(wd_dec) < bkt_level) begin
              bkt_level <= BIW'(wd_dec);
            end
          end
          if (!vs_rd && int'(entry_alloc) < POOL) begin
            state <= ST_V_PUSH;
          end else begin
            ptr   <= ptr_next;
            state <= ST_V_NXT;
          end
        end
        ST_V_PUSH: begin
          entry_alloc <= entry_alloc + PW'(1);
          ptr         <= ptr_next;
          state       <= ST_V_NXT;
        end
        // hand the result to the output register
        ST_OUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {3'b000, dropped_flag, res_rank, res_vertex};
            m_tuser  <= res_status;
            m_tlast  <= res_last;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- dv/degeneracy_order_engine_core_tb.sv -----
// degeneracy_order_engine_core_tb: self-checking bench for the degeneracy order engine
// drives edge, next and clear transactions, predicts each ordered vertex, checks the results
// depends on doe_pkg and degeneracy_order_engine_core
module degeneracy_order_engine_core_tb
  import doe_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV      = DEF_MAX_VERTICES;
  localparam int NE      = DEF_MAX_EDGES;
  localparam int NBR_D   = 2 * NE;
  localparam int NBKT    = 2 * NE + 1;
  localparam int POOL_D  = NV + NE;
  localparam int QUIET   = 24;
  localparam int MAX_REP = 10;

  // command code with no meaning, expected to be ignored
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [1:0] {ST_LOAD, ST_ORDER, ST_DONE} order_state_t;
  typedef enum logic [1:0] {K_ITEM, K_CFG, K_WAIT} entry_kind_t;

  typedef struct {
    entry_kind_t      kind;
    logic [CMD_W-1:0] cmd;
    logic [VTX_W-1:0] va;
    logic [VTX_W-1:0] vb;
    logic [CFG_W-1:0] cfg;
  } stim_t;

  typedef struct {
    logic [VTX_W-1:0] vtx;
    logic [VTX_W-1:0] rank;
    logic             last;
    logic             status;
    logic             dropped;
  } order_res_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wen = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;
  logic [CMD_W-1:0]  s_tuser = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic [0:0]        m_tuser;
  logic              m_tlast;

  degeneracy_order_engine_core dut (
    .clk(clk), .rst(rst),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ordering predictor state, pointers kept as index + 1
  int unsigned  vcount;
  int unsigned  nbr_vtx [NBR_D];
  int unsigned  nbr_link [NBR_D];
  int unsigned  head [NV];
  int unsigned  tail [NV];
  int unsigned  deg [NV];
  int unsigned  wdeg [NV];
  bit           seen [NV];
  int unsigned  bkt_vtx [POOL_D];
  int unsigned  bkt_link [POOL_D];
  int unsigned  bkt_top [NBKT];
  int unsigned  n_edges, deg_max, bkt_idx, rank_ctr, pool_used;
  bit           drop_seen;
  order_state_t ord_state;

  stim_t      stim_q [$];
  order_res_t order_q [$];
  bit         fill_done = 1'b0;
  int         mismatches = 0;
  int         n_accepted = 0, n_results = 0, n_empty = 0, n_last = 0, n_cfg = 0;

  function automatic int unsigned live_n();
    return (vcount > NV) ? NV : vcount;
  endfunction

  function automatic void graph_clear();
    for (int i = 0; i < NBR_D; i++) begin
      nbr_vtx[i] = 0;
      nbr_link[i] = 0;
    end
    for (int i = 0; i < NV; i++) begin
      head[i] = 0; tail[i] = 0; deg[i] = 0; wdeg[i] = 0; seen[i] = 0;
    end
    for (int i = 0; i < POOL_D; i++) begin
      bkt_vtx[i] = 0;
      bkt_link[i] = 0;
    end
    for (int i = 0; i < NBKT; i++) bkt_top[i] = 0;
    n_edges = 0; deg_max = 0; bkt_idx = 0; rank_ctr = 0; pool_used = 0;
    drop_seen = 0;
    ord_state = ST_LOAD;
  endfunction

  function automatic void list_add(int unsigned v, int unsigned w, int unsigned slot);
    nbr_vtx[slot] = w;
    nbr_link[slot] = 0;
    if (tail[v] != 0 && tail[v] <= NBR_D) nbr_link[tail[v] - 1] = slot + 1;
    else head[v] = slot + 1;
    tail[v] = slot + 1;
  endfunction

  function automatic void bucket_add(int unsigned v, int unsigned d);
    if (d >= NBKT || pool_used >= POOL_D) return;
    bkt_vtx[pool_used] = v;
    bkt_link[pool_used] = bkt_top[d];
    bkt_top[d] = pool_used + 1;
    pool_used++;
  endfunction

  function automatic void edge_load(int unsigned a, int unsigned b);
    int unsigned n;
    n = live_n();
    if (ord_state != ST_LOAD || a >= n || b >= n || a == b || n_edges >= NE) begin
      drop_seen = 1;
      return;
    end
    list_add(a, b, 2 * n_edges);
    list_add(b, a, 2 * n_edges + 1);
    deg[a]++;
    deg[b]++;
    if (deg[a] > deg_max) deg_max = deg[a];
    if (deg[b] > deg_max) deg_max = deg[b];
    n_edges++;
  endfunction

  // mark a vertex and demote its unvisited neighbours
  function automatic void vertex_visit(int unsigned v);
    int unsigned p, w, guard;
    p = head[v];
    guard = 0;
    seen[v] = 1;
    while (p != 0 && p <= NBR_D && guard < NBR_D) begin
      w = nbr_vtx[p - 1];
      if (w < NV && !seen[w]) begin
        if (wdeg[w] > 0) wdeg[w]--;
        bucket_add(w, wdeg[w]);
        if (wdeg[w] < bkt_idx) bkt_idx = wdeg[w];
      end
      p = nbr_link[p - 1];
      guard++;
    end
  endfunction

  // next vertex of the smallest-last order
  function automatic order_res_t next_in_order();
    order_res_t  r;
    int unsigned n, top, v;
    n = live_n();
    if (ord_state == ST_LOAD) begin
      for (int i = 0; i < NV; i++) begin
        seen[i] = (i >= n);
        wdeg[i] = deg[i];
      end
      for (int i = 0; i < n; i++) bucket_add(i, deg[i]);
      bkt_idx = 0;
      rank_ctr = 0;
      ord_state = (n == 0) ? ST_DONE : ST_ORDER;
    end
    r = '{vtx: '0, rank: '0, last: 1'b0, status: 1'b1, dropped: drop_seen};
    if (ord_state == ST_ORDER) begin
      while (bkt_idx <= deg_max && bkt_idx < NBKT) begin
        top = bkt_top[bkt_idx];
        if (top == 0 || top > POOL_D) begin
          bkt_idx++;
          continue;
        end
        bkt_top[bkt_idx] = bkt_link[top - 1];
        v = bkt_vtx[top - 1];
        if (v >= NV || seen[v]) continue;
        vertex_visit(v);
        r.vtx = v[VTX_W-1:0];
        r.rank = rank_ctr[VTX_W-1:0];
        rank_ctr++;
        if (rank_ctr >= n) begin
          r.last = 1'b1;
          ord_state = ST_DONE;
        end
        r.status = 1'b0;
        return r;
      end
      ord_state = ST_DONE;
    end
    return r;
  endfunction

  function automatic void add_item(logic [CMD_W-1:0] c, int unsigned a, int unsigned b);
    stim_t s;
    s = '{kind: K_ITEM, cmd: c, va: a[VTX_W-1:0], vb: b[VTX_W-1:0], cfg: '0};
    stim_q.insert(stim_q.size(), s);
  endfunction

  function automatic void add_cfg(int unsigned v);
    stim_t s;
    s = '{kind: K_CFG, cmd: CMD_LOAD, va: '0, vb: '0, cfg: v[CFG_W-1:0]};
    stim_q.insert(stim_q.size(), s);
  endfunction

  function automatic void add_wait();
    stim_t s;
    s = '{kind: K_WAIT, cmd: CMD_LOAD, va: '0, vb: '0, cfg: '0};
    stim_q.insert(stim_q.size(), s);
  endfunction

  // one graph: size, edges with some noise, ordering, clear
  function automatic void add_graph(int unsigned n, int unsigned n_ld, int unsigned n_nx);
    int unsigned a, b, sel;
    add_cfg(n);
    for (int i = 0; i < n_ld; i++) begin
      sel = $urandom_range(0, 19);
      if (n >= 2 && sel < 17) begin
        a = $urandom_range(0, n - 1);
        b = (a + $urandom_range(1, n - 1)) % n;
        add_item(CMD_LOAD, a, b);
      end else if (sel == 17) begin
        a = $urandom_range(0, 1023);
        add_item(CMD_LOAD, a, a);
      end else if (sel == 18) begin
        add_item(CMD_LOAD, $urandom_range(0, 1023), $urandom_range(0, 1023));
      end else begin
        add_item(CMD_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 1023));
      end
    end
    // occasionally shrink the vertex count before ordering
    if (n > 2 && $urandom_range(0, 5) == 0) begin
      add_wait();
      add_cfg($urandom_range(1, n - 1));
    end
    for (int i = 0; i < n_nx; i++) begin
      add_item(CMD_NEXT, 0, 0);
      if ($urandom_range(0, 30) == 0) add_item(CMD_LOAD, 0, 1);
    end
    if ($urandom_range(0, 4) == 0) begin
      add_wait();
      add_cfg($urandom_range(0, 2047));
      add_item(CMD_NEXT, 0, 0);
    end
    if ($urandom_range(0, 2) == 0) add_wait();
    add_item(CMD_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1023));
  endfunction

  // stimulus plan
  initial begin
    int unsigned n, a;
    vcount = 0;
    graph_clear();
    // empty graph, then tiny graph with self-loop, out-of-range and late-load drops
    add_item(CMD_NEXT, 0, 0);
    add_item(CMD_CLEAR, 0, 0);
    add_cfg(2);
    add_item(CMD_LOAD, 0, 1);
    add_item(CMD_LOAD, 1, 1);
    add_item(CMD_LOAD, 0, 2);
    add_item(CMD_LOAD, 1023, 1023);
    add_item(CMD_UNUSED, 1023, 1023);
    add_item(CMD_NEXT, 0, 0);
    add_item(CMD_NEXT, 0, 0);
    add_item(CMD_NEXT, 0, 0);
    add_item(CMD_LOAD, 1, 0);
    add_cfg(5);
    add_item(CMD_NEXT, 0, 0);
    add_item(CMD_CLEAR, 0, 0);
    // largest counts, duplicate edges, then a shrunk count
    add_cfg(1024);
    add_item(CMD_LOAD, 0, 1023);
    add_item(CMD_LOAD, 1023, 0);
    add_item(CMD_NEXT, 0, 0);
    add_item(CMD_CLEAR, 0, 0);
    add_cfg(2047);
    add_item(CMD_LOAD, 1023, 1022);
    add_item(CMD_NEXT, 0, 0);
    add_item(CMD_CLEAR, 0, 0);
    add_cfg(6);
    add_item(CMD_LOAD, 0, 5);
    add_item(CMD_LOAD, 4, 5);
    add_item(CMD_LOAD, 1, 2);
    add_wait();
    add_cfg(3);
    for (int i = 0; i < 4; i++) add_item(CMD_NEXT, 0, 0);
    add_item(CMD_CLEAR, 0, 0);
    // denser graph with repeated edges, ordered past its end
    add_cfg(64);
    for (int i = 0; i < 300; i++) begin
      a = $urandom_range(0, 63);
      add_item(CMD_LOAD, a, (a + $urandom_range(1, 63)) % 64);
    end
    for (int i = 0; i < 66; i++) add_item(CMD_NEXT, 0, 0);
    add_wait();
    add_item(CMD_CLEAR, 0, 0);
    // random small graphs
    for (int g = 0; g < 15; g++) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 24);
      add_graph(n, $urandom_range(0, 3 * n + 2),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, n) : n + $urandom_range(0, 2));
    end
    fill_done = 1'b1;
  end

  // sender: bursts and gaps, configuration writes and drains when the block is idle
  stim_t            cur;
  order_res_t       pred;
  int               burst_left = 4, gap_left = 0, quiet = 0;
  logic             valid_n, wen_n;
  logic [CFG_W-1:0] wdata_n;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      cfg_wen <= 1'b0;
    end else begin
      valid_n = s_tvalid;
      wen_n = 1'b0;
      wdata_n = cfg_wdata;
      if (s_tvalid && s_tready) begin
        n_accepted++;
        if (cur.cmd == CMD_LOAD) edge_load(cur.va, cur.vb);
        else if (cur.cmd == CMD_CLEAR) graph_clear();
        else if (cur.cmd == CMD_NEXT) begin
          pred = next_in_order();
          order_q.insert(order_q.size(), pred);
        end
        valid_n = 1'b0;
      end
      if (!valid_n) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_q.size() > 0) begin
          if (stim_q[0].kind == K_ITEM) begin
            cur = stim_q.pop_front();
            valid_n = 1'b1;
            s_tdata <= {{(DATA_W-2*VTX_W){1'b0}}, cur.vb, cur.va};
            s_tuser <= cur.cmd;
            burst_left--;
            if (burst_left <= 0) begin
              burst_left = $urandom_range(1, 24);
              gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
          end else begin
            // drain: nothing outstanding, block ready for a quiet stretch
            if (order_q.size() == 0 && s_tready) quiet++;
            else quiet = 0;
            if (quiet >= QUIET) begin
              quiet = 0;
              if (stim_q[0].kind == K_CFG) begin
                wen_n = 1'b1;
                wdata_n = stim_q[0].cfg;
                n_cfg++;
                if (ord_state == ST_LOAD) vcount = stim_q[0].cfg;
              end
              void'(stim_q.pop_front());
            end
          end
        end
      end
      s_tvalid <= valid_n;
      cfg_wen <= wen_n;
      cfg_wdata <= wdata_n;
    end
  end

  // receiver stall pattern, switching among four modes
  int unsigned cyc = 0;
  always @(posedge clk) begin
    cyc++;
    case ((cyc >> 8) % 4)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom_range(0, 1));
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= cyc[3];
    endcase
  end

  // result monitor and field checks
  order_res_t exp_r;
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (order_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REP)
          $display("unexpected result: vertex %0d rank %0d", m_tdata[9:0], m_tdata[19:10]);
      end else begin
        exp_r = order_q.pop_front();
        if (exp_r.status) n_empty++;
        if (exp_r.last) n_last++;
        if (m_tdata[9:0] !== exp_r.vtx || m_tdata[19:10] !== exp_r.rank ||
            m_tdata[20] !== exp_r.dropped || m_tuser[0] !== exp_r.status ||
            m_tlast !== exp_r.last) begin
          mismatches++;
          if (mismatches <= MAX_REP)
            $display("mismatch: exp vtx %0d rank %0d last %0b st %0b drop %0b, got %0d %0d %0b %0b %0b",
                     exp_r.vtx, exp_r.rank, exp_r.last, exp_r.status, exp_r.dropped,
                     m_tdata[9:0], m_tdata[19:10], m_tlast, m_tuser[0], m_tdata[20]);
        end
      end
    end
  end

  // reset, end of run and verdict
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (!(fill_done && stim_q.size() == 0 && !s_tvalid && order_q.size() == 0))
      @(posedge clk);
    repeat (64) @(posedge clk);
    $display("covered %0d transactions, %0d results (%0d order ends, %0d empty or finished)",
             n_accepted, n_results, n_last, n_empty);
    $display("vertex count written %0d times, %0d mismatches", n_cfg, mismatches);
    if (mismatches == 0 && order_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #30ms;
    $display("timeout");
    $display("status: fail");
    $finish;
  end

endmodule
